/* sv/krs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the key release scanner.
// No dependencies.
package krs_pkg;

  localparam int KeyCount    = 10;
  localparam int KeysPerWord = 5;
  localparam int ValueW      = 7;
  localparam int KeyWordW    = KeysPerWord * ValueW;
  localparam int FifoSlots   = 10;
  localparam int SlotW       = $clog2(FifoSlots);
  localparam int KeyCountW   = 4;
  localparam int TickW       = 8;
  localparam int CfgIndexW   = 3;

  localparam logic [TickW-1:0] TickDivideReset = TickW'(20);

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_KEY_COUNT   = 3'd0,
    CFG_PRESS_MASK  = 3'd1,
    CFG_VALUES_LOW  = 3'd2,
    CFG_VALUES_HIGH = 3'd3,
    CFG_TICK_DIVIDE = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic push;
    logic pop;
  } krs_fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } krs_fifo_stat_t;

endpackage

/* sv/krs_event_fifo.sv */
`timescale 1ns / 1ps
// Ring FIFO of released key values; one slot stays free to tell full from empty.
// Depends on krs_pkg.
module krs_event_fifo
  import krs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  krs_fifo_ctl_t        ctl,
  input  logic [ValueW-1:0]    push_value,
  output krs_fifo_stat_t       status,
  output logic [ValueW-1:0]    head_value
);

  logic [ValueW-1:0] store_r [FifoSlots];
  logic [SlotW-1:0]  rd_slot_r, rd_slot_nxt;
  logic [SlotW-1:0]  wr_slot_r, wr_slot_nxt;
  logic [SlotW-1:0]  wr_next, rd_next;
  logic              do_push, do_pop;

  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] s);
    logic [SlotW-1:0] r;
    if (s == SlotW'(FifoSlots - 1)) begin
      r = '0;
    end else begin
      r = s + SlotW'(1);
    end
    return r;
  endfunction

  assign wr_next      = next_slot(wr_slot_r);
  assign rd_next      = next_slot(rd_slot_r);
  assign status.empty = (rd_slot_r == wr_slot_r);
  assign status.full  = (wr_next == rd_slot_r);
  assign head_value   = store_r[rd_slot_r];
  assign do_push      = ctl.push && !status.full;
  assign do_pop       = ctl.pop && !status.empty;

  always_comb begin
    wr_slot_nxt = do_push ? wr_next : wr_slot_r;
    rd_slot_nxt = do_pop ? rd_next : rd_slot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_slot_r <= '0;
      wr_slot_r <= '0;
    end else begin
      rd_slot_r <= rd_slot_nxt;
      wr_slot_r <= wr_slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_slot_r] <= push_value;
    end
  end

`ifndef NO_ASSERTIONS
  a_not_empty_and_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(status.empty && status.full))
    else $error("fifo reports empty and full together");

  a_full_drops_push: assert property (@(posedge clk) disable iff (!rst_n)
    status.full && !ctl.pop |=> $stable(wr_slot_r))
    else $error("write slot moved while full");

  a_slots_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_slot_r < SlotW'(FifoSlots)) && (wr_slot_r < SlotW'(FifoSlots)))
    else $error("slot index out of range");
`endif

endmodule

/* sv/key_release_scanner_fifo_core.sv */
`timescale 1ns / 1ps
// Key release scanner: tick divider, priority key scan and event FIFO pops.
// Depends on krs_pkg and krs_event_fifo.
// A pop item is held in the input stage, then its result is written to the result register.
// Throughput: one item per cycle; a pop waits only while the result register holds an
// item that is not taken in the same cycle.
// Reset (synchronous, rst_n low): registers to defaults, tick count zero, no key held,
// FIFO empty; the FIFO store itself is not cleared. Config writes take effect at once.
module key_release_scanner_fifo_core
  import krs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [KeyCount-1:0]   in_key_levels,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ValueW-1:0]     out_key_value,
  output logic                  out_fifo_was_empty,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CfgIndexW-1:0]  cfg_index,
  input  logic [KeyWordW-1:0]   cfg_data
);

  logic [KeyCountW-1:0] key_count_r;
  logic [KeyCount-1:0]  press_mask_r;
  logic [KeyWordW-1:0]  values_low_r;
  logic [KeyWordW-1:0]  values_high_r;
  logic [TickW-1:0]     tick_div_r;

  logic                 s1_valid_r, s1_valid_nxt;
  op_t                  s1_op_r;
  logic [KeyCount-1:0]  s1_levels_r;
  logic                 s1_adv;

  logic [TickW-1:0]     tick_cnt_r, tick_cnt_nxt;
  logic [TickW-1:0]     tick_inc;
  logic                 cur_valid_r, cur_valid_nxt;
  logic [ValueW-1:0]    cur_key_r, cur_key_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [ValueW-1:0]    out_value_r;
  logic                 out_empty_r;

  logic [ValueW-1:0]    key_val [KeyCount];
  logic                 hit;
  logic [ValueW-1:0]    hit_val;
  logic                 do_tick, do_pop, sample;

  krs_fifo_ctl_t        fifo_ctl;
  krs_fifo_stat_t       fifo_stat;
  logic [ValueW-1:0]    fifo_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r   <= '0;
      press_mask_r  <= '0;
      values_low_r  <= '0;
      values_high_r <= '0;
      tick_div_r    <= TickDivideReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KEY_COUNT:   key_count_r   <= cfg_data[KeyCountW-1:0];
        CFG_PRESS_MASK:  press_mask_r  <= cfg_data[KeyCount-1:0];
        CFG_VALUES_LOW:  values_low_r  <= cfg_data;
        CFG_VALUES_HIGH: values_high_r <= cfg_data;
        CFG_TICK_DIVIDE: tick_div_r    <= cfg_data[TickW-1:0];
        default: ;
      endcase
    end
  end

  // hold a pop while the result register is still occupied and not being taken
  assign s1_adv   = s1_valid_r && !(s1_op_r == OP_POP && out_valid_r && !out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign do_tick  = s1_adv && (s1_op_r == OP_TICK);
  assign do_pop   = s1_adv && (s1_op_r == OP_POP);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r     <= op_t'(in_opcode);
      s1_levels_r <= in_key_levels;
    end
  end

  for (genvar g = 0; g < KeyCount; g++) begin : g_val
    if (g < KeysPerWord) begin : g_lo
      assign key_val[g] = values_low_r[ValueW*g +: ValueW];
    end else begin : g_hi
      assign key_val[g] = values_high_r[ValueW*(g-KeysPerWord) +: ValueW];
    end
  end

  // lowest matching key wins
  always_comb begin
    hit     = 1'b0;
    hit_val = '0;
    for (int i = KeyCount - 1; i >= 0; i--) begin
      if ((int'(key_count_r) > i) && (s1_levels_r[i] == press_mask_r[i])) begin
        hit     = 1'b1;
        hit_val = key_val[i];
      end
    end
  end

  assign tick_inc = tick_cnt_r + TickW'(1);
  assign sample   = do_tick && (tick_inc >= tick_div_r);

  always_comb begin
    tick_cnt_nxt  = tick_cnt_r;
    cur_valid_nxt = cur_valid_r;
    cur_key_nxt   = cur_key_r;
    if (do_tick) begin
      tick_cnt_nxt = sample ? '0 : tick_inc;
    end
    if (sample) begin
      cur_valid_nxt = hit;
      cur_key_nxt   = hit_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_cnt_r  <= '0;
      cur_valid_r <= 1'b0;
      cur_key_r   <= '0;
    end else begin
      tick_cnt_r  <= tick_cnt_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_key_r   <= cur_key_nxt;
    end
  end

  assign fifo_ctl.push = sample && !hit && cur_valid_r;
  assign fifo_ctl.pop  = do_pop && !fifo_stat.empty;

  krs_event_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (fifo_ctl),
    .push_value (cur_key_r),
    .status     (fifo_stat),
    .head_value (fifo_head)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (do_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      out_value_r <= fifo_stat.empty ? '0 : fifo_head;
      out_empty_r <= fifo_stat.empty;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_key_value      = out_value_r;
  assign out_fifo_was_empty = out_empty_r;

`ifndef NO_ASSERTIONS
  a_empty_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fifo_was_empty |-> out_key_value == '0)
    else $error("empty pop returned a nonzero value");

  a_pop_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_op_r == OP_POP && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while a pop is stalled");

  a_push_only_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_ctl.push |=> !cur_valid_r)
    else $error("push without a release");
`endif

endmodule

/* tb/key_release_scanner_fifo_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for key_release_scanner_fifo_core: directed table, then random phases.
// Depends on krs_pkg and the core; an in-bench scanner model predicts every pop result not fixed by the table.
module key_release_scanner_fifo_core_tb;
  import krs_pkg::*;

  localparam int ClkHalf    = 4;
  localparam int WatchLimit = 2000;
  localparam int ShowLimit  = 10;
  localparam int Settle     = 4;
  localparam int Phases     = 8;
  localparam logic [CfgIndexW-1:0] CfgSpare = CfgIndexW'(5);
  localparam logic [KeyCount-1:0]  AllKeys  = '1;
  localparam logic [KeyCount-1:0]  NoKeys   = '0;
  localparam logic [KeyCount-1:0]  TopKey   = KeyCount'(1) << (KeyCount - 1);

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              empty;
  } pop_result_t;

  typedef struct packed {
    bit                   is_cfg;
    logic [CfgIndexW-1:0] idx;
    logic [KeyWordW-1:0]  data;
    op_t                  op;
    logic [KeyCount-1:0]  levels;
    bit                   fixed;
    pop_result_t          want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  op_t                  in_opcode = OP_TICK;
  logic [KeyCount-1:0]  in_key_levels = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ValueW-1:0]    out_key_value;
  logic                 out_fifo_was_empty;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [KeyWordW-1:0]  cfg_data = '0;

  bit          drv_fixed = 1'b0;
  pop_result_t drv_want = '0;
  bit          no_idle = 1'b0;
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          ready_hold = 0;

  logic [KeyCountW-1:0] key_cnt = '0;
  logic [KeyCount-1:0]  press_mask = '0;
  logic [KeyWordW-1:0]  vals_lo = '0;
  logic [KeyWordW-1:0]  vals_hi = '0;
  logic [TickW-1:0]     tick_div = TickDivideReset;
  logic [TickW-1:0]     tick_cnt = '0;
  bit                   cur_held = 1'b0;
  logic [ValueW-1:0]    cur_val = '0;
  bit                   prev_held = 1'b0;
  logic [ValueW-1:0]    prev_val = '0;
  logic [ValueW-1:0]    release_store [FifoSlots];
  int                   rd_slot = 0;
  int                   wr_slot = 0;

  pop_result_t pending_pops [$];
  plan_row_t   plan [$];

  key_release_scanner_fifo_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_key_levels      (in_key_levels),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_key_value      (out_key_value),
    .out_fifo_was_empty (out_fifo_was_empty),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [KeyWordW-1:0] rand_word();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[KeyWordW-1:0];
  endfunction

  function automatic plan_row_t cfg_row(input logic [CfgIndexW-1:0] idx,
                                        input logic [KeyWordW-1:0] data);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  function automatic plan_row_t tick_row(input logic [KeyCount-1:0] lv);
    plan_row_t row;
    row = '0;
    row.op = OP_TICK;
    row.levels = lv;
    return row;
  endfunction

  function automatic plan_row_t pop_row(input bit fixed, input logic [ValueW-1:0] value,
                                        input logic empty);
    plan_row_t row;
    row = '0;
    row.op = OP_POP;
    row.levels = KeyCount'($urandom);
    row.fixed = fixed;
    row.want.value = value;
    row.want.empty = empty;
    return row;
  endfunction

  task automatic note_fail(input string msg);
    fail_count++;
    if (fail_count <= ShowLimit) $display("%s", msg);
  endtask

  // Advance the scanner model by one item; a pop yields the released key it returns.
  task automatic scan_item(input op_t op, input logic [KeyCount-1:0] lv,
                           output bit has_res, output pop_result_t res);
    int n;
    int i;
    has_res = 1'b0;
    res = '0;
    if (op == OP_TICK) begin
      tick_cnt = tick_cnt + TickW'(1);
      if (tick_cnt >= tick_div) begin
        tick_cnt = '0;
        n = (key_cnt > KeyCount) ? KeyCount : int'(key_cnt);
        prev_held = cur_held;
        prev_val = cur_val;
        cur_held = 1'b0;
        cur_val = '0;
        for (i = 0; i < n; i++) begin
          if (!cur_held && lv[i] == press_mask[i]) begin
            cur_held = 1'b1;
            cur_val = (i < KeysPerWord) ? vals_lo[ValueW*i +: ValueW]
                                        : vals_hi[ValueW*(i-KeysPerWord) +: ValueW];
          end
        end
        if (!cur_held && prev_held && ((wr_slot + 1) % FifoSlots) != rd_slot) begin
          release_store[wr_slot] = prev_val;
          wr_slot = (wr_slot + 1) % FifoSlots;
        end
      end
    end else begin
      has_res = 1'b1;
      if (rd_slot == wr_slot) begin
        res.empty = 1'b1;
      end else begin
        res.value = release_store[rd_slot];
        rd_slot = (rd_slot + 1) % FifoSlots;
      end
    end
  endtask

  task automatic send_item(input op_t op, input logic [KeyCount-1:0] lv, input bit fixed,
                           input pop_result_t want);
    int gap;
    gap = no_idle ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_key_levels <= lv;
    drv_fixed <= fixed;
    drv_want <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drain all pops and let trailing ticks settle before touching a register.
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [KeyWordW-1:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pops.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int items, input int pop_pct);
    int hold;
    int n;
    int k;
    int r;
    logic [KeyCount-1:0] lv;
    logic [KeyCount-1:0] scanned;
    hold = 0;
    lv = '0;
    n = (key_cnt > KeyCount) ? KeyCount : int'(key_cnt);
    scanned = KeyCount'((1 << n) - 1);
    repeat (items) begin
      if (hold == 0) begin
        r = $urandom_range(0, 99);
        lv = KeyCount'($urandom);
        if (r < 45) begin
          lv = (~press_mask & scanned) | (lv & ~scanned);
        end else if (r < 90 && n > 0) begin
          k = $urandom_range(0, n - 1);
          lv[k] = press_mask[k];
        end
        hold = $urandom_range(1, 2 * ((tick_div == 0) ? 1 : int'(tick_div)));
      end
      if ($urandom_range(0, 99) < pop_pct) begin
        send_item(OP_POP, KeyCount'($urandom), 1'b0, '0);
      end else begin
        send_item(OP_TICK, lv, 1'b0, '0);
        hold = hold - 1;
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    bit got;
    pop_result_t res;
    pop_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KEY_COUNT:   key_cnt = cfg_data[KeyCountW-1:0];
          CFG_PRESS_MASK:  press_mask = cfg_data[KeyCount-1:0];
          CFG_VALUES_LOW:  vals_lo = cfg_data;
          CFG_VALUES_HIGH: vals_hi = cfg_data;
          CFG_TICK_DIVIDE: tick_div = cfg_data[TickW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        scan_item(in_opcode, in_key_levels, got, res);
        if (got) pending_pops.push_back(drv_fixed ? drv_want : res);
      end
      if (out_valid && out_ready) begin
        if (pending_pops.size() == 0) begin
          note_fail($sformatf("unexpected item: key_value %0h fifo_was_empty %0b",
                              out_key_value, out_fifo_was_empty));
        end else begin
          want = pending_pops.pop_front();
          if (out_key_value !== want.value)
            note_fail($sformatf("key_value mismatch: expected %0h actual %0h",
                                want.value, out_key_value));
          if (out_fifo_was_empty !== want.empty)
            note_fail($sformatf("fifo_was_empty mismatch: expected %0b actual %0b",
                                want.empty, out_fifo_was_empty));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold = ready_hold - 1;
    end else if (no_idle || !out_ready) begin
      out_ready <= 1'b1;
      ready_hold = $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b0;
      ready_hold = gap_len();
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("key_release_scanner_fifo_core_tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int p;
    int kc;
    int div;
    logic [KeyWordW-1:0] d;

    plan.push_back(pop_row(1'b1, '0, 1'b1));
    plan.push_back(cfg_row(CFG_TICK_DIVIDE, KeyWordW'(1)));
    plan.push_back(cfg_row(CFG_KEY_COUNT, KeyWordW'(KeyCount)));
    plan.push_back(cfg_row(CFG_PRESS_MASK, KeyWordW'(AllKeys)));
    plan.push_back(cfg_row(CFG_VALUES_LOW, {7'd5, 7'd4, 7'd3, 7'd2, 7'h7F}));
    plan.push_back(cfg_row(CFG_VALUES_HIGH, {7'd0, 7'd9, 7'd8, 7'd7, 7'd6}));
    plan.push_back(tick_row(AllKeys));
    plan.push_back(tick_row(NoKeys));
    plan.push_back(pop_row(1'b1, 7'h7F, 1'b0));
    plan.push_back(tick_row(TopKey));
    plan.push_back(tick_row(NoKeys));
    plan.push_back(pop_row(1'b0, '0, 1'b0));
    plan.push_back(cfg_row(CFG_KEY_COUNT, KeyWordW'(15)));
    plan.push_back(cfg_row(CfgSpare, '1));
    plan.push_back(tick_row(TopKey));
    plan.push_back(tick_row(AllKeys));
    plan.push_back(tick_row(NoKeys));
    plan.push_back(pop_row(1'b0, '0, 1'b0));
    plan.push_back(pop_row(1'b1, '0, 1'b1));
    plan.push_back(cfg_row(CFG_KEY_COUNT, '0));
    plan.push_back(tick_row(AllKeys));
    plan.push_back(tick_row(NoKeys));
    plan.push_back(pop_row(1'b1, '0, 1'b1));
    plan.push_back(cfg_row(CFG_TICK_DIVIDE, '0));
    plan.push_back(cfg_row(CFG_KEY_COUNT, KeyWordW'(KeyCount)));
    plan.push_back(cfg_row(CFG_PRESS_MASK, '0));
    plan.push_back(tick_row(NoKeys));
    plan.push_back(tick_row(AllKeys));
    plan.push_back(pop_row(1'b0, '0, 1'b0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        write_reg(plan[i].idx, plan[i].data);
      else
        send_item(plan[i].op, plan[i].levels, plan[i].fixed, plan[i].want);
    end

    for (p = 0; p < Phases; p++) begin
      no_idle = (p == 3 || p == 6);
      kc = (p <= 1) ? KeyCount : (p == 4) ? 15 : (p == 5) ? 0 : $urandom_range(0, 15);
      div = (p == 0) ? 1 : (p == 1) ? 255 : (p == 2) ? 0 :
            (p == 7) ? $urandom_range(0, 255) : $urandom_range(1, 6);
      d = rand_word();
      d[KeyCountW-1:0] = KeyCountW'(kc);
      write_reg(CFG_KEY_COUNT, d);
      d = rand_word();
      if (p == 0) d[KeyCount-1:0] = NoKeys;
      if (p == 1) d[KeyCount-1:0] = AllKeys;
      write_reg(CFG_PRESS_MASK, d);
      write_reg(CFG_VALUES_LOW, (p == 6) ? '1 : rand_word());
      write_reg(CFG_VALUES_HIGH, (p == 6) ? '1 : rand_word());
      d = rand_word();
      d[TickW-1:0] = TickW'(div);
      write_reg(CFG_TICK_DIVIDE, d);
      run_phase((p == 1) ? 500 : 220,
                (p == 0) ? 10 : (p == 2) ? 60 : $urandom_range(15, 50));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pops.size() != 0) @(posedge clk);
    repeat (2 * Settle) @(posedge clk);
    if (pending_pops.size() != 0) note_fail("results still outstanding at end of run");
    if (fail_count == 0)
      $display("key_release_scanner_fifo_core_tb OK");
    else
      $display("key_release_scanner_fifo_core_tb NOT OK");
    $finish;
  end

endmodule
